// ===== hdl/zrle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrle_pkg
// Shared types and constants of the ZRLE tile stream decoder.
// ----------------------------------------------------------------------------
package zrle_pkg;

   localparam int TILE_SIZE        = 64;
   localparam int PALETTE_DEPTH    = 127;
   localparam int MAX_CPIXEL_BYTES = 4;

   localparam int PAL_AW = 7;

   localparam logic [1:0] CSR_RECT_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_RECT_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CPIXEL      = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_SUBENC    = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED = 2'd3;

   localparam logic [7:0] SUBENC_RAW       = 8'd0;
   localparam logic [7:0] SUBENC_SOLID     = 8'd1;
   localparam logic [7:0] SUBENC_PACK_MAX  = 8'd16;
   localparam logic [7:0] SUBENC_PLAIN_RLE = 8'h80;
   localparam logic [7:0] SUBENC_PRLE_MIN  = 8'd130;
   localparam logic [7:0] RUN_CONTINUE     = 8'd255;

   typedef enum logic [7:0] {
      PH_SUBENC     = 8'b0000_0001,
      PH_RAW        = 8'b0000_0010,
      PH_SOLID      = 8'b0000_0100,
      PH_PALETTE    = 8'b0000_1000,
      PH_PACKED     = 8'b0001_0000,
      PH_PLAIN_PIX  = 8'b0010_0000,
      PH_RUN_LEN    = 8'b0100_0000,
      PH_PRLE_INDEX = 8'b1000_0000
   } zrle_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } zrle_req_type;

   typedef struct packed {
      logic [15:0] tile_x;
      logic [15:0] tile_y;
      logic [6:0]  tile_w;
      logic [6:0]  tile_h;
      logic [11:0] run_start;
      logic [12:0] run_len;
      logic [31:0] pixel_value;
      logic        tile_done;
      logic        rect_done;
      logic [1:0]  error_code;
      logic        last_of_byte;
   } zrle_rsp_type;

   typedef struct packed {
      zrle_rsp_type      rsp;
      logic              from_palette;
      logic [PAL_AW-1:0] pal_index;
   } zrle_run_type;

   typedef struct packed {
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [2:0]  bytes_per_cpixel;
   } zrle_cfg_type;

endpackage
`default_nettype wire

// ===== hdl/zrle_palette_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrle_palette_ram
// Palette store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module zrle_palette_ram
   import zrle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [PAL_AW-1:0] wr_addr,
   input  wire logic [31:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [PAL_AW-1:0] rd_addr,
   output logic [31:0]            rd_data
);

   logic [31:0] mem [PALETTE_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/zrle_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrle_parser
// Byte parser and tile walker: at most one decoded run per cycle while run_ready is high, palette access.
// ----------------------------------------------------------------------------
module zrle_parser
   import zrle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire zrle_cfg_type      cfg,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire zrle_req_type      req_data,
   input  wire logic              run_ready,
   output logic                   run_valid,
   output zrle_run_type           run,
   output logic                   pal_wr_en,
   output logic [PAL_AW-1:0]      pal_wr_addr,
   output logic [31:0]            pal_wr_data
);

   zrle_phase_type phase_ff, phase_in;
   logic [7:0]  sub_ff, sub_in;
   logic [6:0]  fill_ff, fill_in;
   logic [31:0] pix_ff, pix_in;
   logic [1:0]  pbc_ff, pbc_in;
   logic [15:0] tx_ff, tx_in;
   logic [15:0] ty_ff, ty_in;
   logic [12:0] off_ff, off_in;
   logic [16:0] acc_ff, acc_in;
   logic [6:0]  col_ff, col_in;
   logic        fin_ff, fin_in;
   logic [2:0]  q_ff, q_in;
   logic [6:0]  idx_ff, idx_in;

   logic        fire, act, act_after, byte_done;
   logic [15:0] rem_w, rem_h;
   logic [6:0]  tw, th;
   logic [12:0] area, remain;
   logic [2:0]  cpb, pcount;
   logic [31:0] pbase, pnew;
   logic        pdone;
   logic [7:0]  byte_v;
   logic [17:0] acc_sum;
   logic [16:0] acc_sat;
   logic [2:0]  pk_bits, pk_last;
   logic [7:0]  pk_mask;
   logic [3:0]  pk_shamt;
   logic [6:0]  pk_idx;
   logic [7:0]  col_next;
   logic [7:0]  fill_next;
   logic        req_run;
   logic [17:0] req_len;
   logic        req_pal;
   logic [6:0]  req_idx;
   logic [31:0] req_val;
   logic        ovf, ends;
   logic [16:0] nx, ny;

   function automatic logic [6:0] pal_clamp(input logic [6:0] idx, input logic [7:0] sub);
      pal_clamp = (idx >= sub[6:0]) ? 7'd0 : idx;
   endfunction

   always_comb begin
      byte_v = req_data.data_byte;
      fire   = req_valid && run_ready;
      act    = !fin_ff && (tx_ff < cfg.rect_width) && (ty_ff < cfg.rect_height);
      rem_w  = (cfg.rect_width > tx_ff) ? cfg.rect_width - tx_ff : 16'd0;
      rem_h  = (cfg.rect_height > ty_ff) ? cfg.rect_height - ty_ff : 16'd0;
      tw     = (rem_w >= 16'(TILE_SIZE)) ? 7'(TILE_SIZE) : rem_w[6:0];
      th     = (rem_h >= 16'(TILE_SIZE)) ? 7'(TILE_SIZE) : rem_h[6:0];
      area   = 13'({6'd0, tw} * {6'd0, th});
      remain = (area > off_ff) ? area - off_ff : 13'd0;
      if (cfg.bytes_per_cpixel == 3'd0) begin
         cpb = 3'd1;
      end else if (cfg.bytes_per_cpixel > 3'(MAX_CPIXEL_BYTES)) begin
         cpb = 3'(MAX_CPIXEL_BYTES);
      end else begin
         cpb = cfg.bytes_per_cpixel;
      end
      pbase  = (pbc_ff == 2'd0) ? 32'd0 : pix_ff;
      pnew   = pbase | ({24'd0, byte_v} << {pbc_ff, 3'b000});
      pcount = {1'b0, pbc_ff} + 3'd1;
      pdone  = pcount >= cpb;
      acc_sum = {1'b0, acc_ff} + {10'd0, byte_v};
      acc_sat = acc_sum[17] ? 17'h1FFFF : acc_sum[16:0];
      fill_next = {1'b0, fill_ff} + 8'd1;
      col_next  = {1'b0, col_ff} + 8'd1;

      if (sub_ff > 8'd4) begin
         pk_bits = 3'd4;
         pk_mask = 8'h0F;
         pk_last = 3'd1;
      end else if (sub_ff > 8'd2) begin
         pk_bits = 3'd2;
         pk_mask = 8'h03;
         pk_last = 3'd3;
      end else begin
         pk_bits = 3'd1;
         pk_mask = 8'h01;
         pk_last = 3'd7;
      end
      pk_shamt = 4'd8 - 4'({1'b0, pk_bits} * ({1'b0, q_ff} + 4'd1));
      pk_idx   = pal_clamp({3'd0, 4'((byte_v >> pk_shamt) & pk_mask)}, sub_ff);

      phase_in = phase_ff;
      sub_in   = sub_ff;
      fill_in  = fill_ff;
      pix_in   = pix_ff;
      pbc_in   = pbc_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      off_in   = off_ff;
      acc_in   = acc_ff;
      col_in   = col_ff;
      fin_in   = fin_ff;
      idx_in   = idx_ff;
      byte_done = 1'b1;
      req_run  = 1'b0;
      req_len  = 18'd1;
      req_pal  = 1'b0;
      req_idx  = 7'd0;
      req_val  = pix_ff;
      pal_wr_en   = 1'b0;
      pal_wr_addr = fill_ff;
      pal_wr_data = pnew;

      run_valid = 1'b0;
      run.rsp.tile_x       = tx_ff;
      run.rsp.tile_y       = ty_ff;
      run.rsp.tile_w       = tw;
      run.rsp.tile_h       = th;
      run.rsp.run_start    = off_ff[11:0];
      run.rsp.run_len      = 13'd0;
      run.rsp.pixel_value  = 32'd0;
      run.rsp.tile_done    = 1'b0;
      run.rsp.rect_done    = 1'b0;
      run.rsp.error_code   = ERR_NONE;
      run.rsp.last_of_byte = 1'b0;
      run.from_palette     = 1'b0;
      run.pal_index        = 7'd0;

      if (act) begin
         case (phase_ff)
            PH_RAW: begin
               pix_in = pnew;
               pbc_in = pdone ? 2'd0 : pcount[1:0];
               req_run = pdone;
               req_val = pnew;
            end
            PH_SOLID: begin
               pix_in = pnew;
               pbc_in = pdone ? 2'd0 : pcount[1:0];
               req_run = pdone;
               req_len = {5'd0, area};
               req_val = pnew;
            end
            PH_PALETTE: begin
               pix_in = pnew;
               pbc_in = pdone ? 2'd0 : pcount[1:0];
               if (pdone) begin
                  pal_wr_en = fire && (fill_ff < 7'(PALETTE_DEPTH));
                  fill_in   = fill_next[6:0];
                  if (fill_next >= {1'b0, sub_ff[6:0]}) begin
                     phase_in = (sub_ff <= SUBENC_PACK_MAX) ? PH_PACKED : PH_PRLE_INDEX;
                  end
               end
            end
            PH_PACKED: begin
               if ({1'b0, col_ff} >= {1'b0, tw}) begin
                  col_in = 7'd0;
               end else begin
                  req_run = 1'b1;
                  req_pal = 1'b1;
                  req_idx = pk_idx;
                  col_in  = col_next[6:0];
                  if (col_next >= {1'b0, tw}) begin
                     col_in = 7'd0;
                  end else if (q_ff != pk_last) begin
                     byte_done = 1'b0;
                  end
               end
            end
            PH_PLAIN_PIX: begin
               pix_in = pnew;
               pbc_in = pdone ? 2'd0 : pcount[1:0];
               if (pdone) begin
                  acc_in   = 17'd0;
                  phase_in = PH_RUN_LEN;
               end
            end
            PH_RUN_LEN: begin
               acc_in = acc_sat;
               if (byte_v != RUN_CONTINUE) begin
                  phase_in = (sub_ff == SUBENC_PLAIN_RLE) ? PH_PLAIN_PIX : PH_PRLE_INDEX;
                  req_run  = 1'b1;
                  req_len  = {1'b0, acc_sat} + 18'd1;
                  req_pal  = sub_ff != SUBENC_PLAIN_RLE;
                  req_idx  = idx_ff;
               end
            end
            PH_PRLE_INDEX: begin
               if (byte_v[7]) begin
                  idx_in   = pal_clamp(byte_v[6:0], sub_ff);
                  acc_in   = 17'd0;
                  phase_in = PH_RUN_LEN;
               end else begin
                  req_run = 1'b1;
                  req_pal = 1'b1;
                  req_idx = pal_clamp(byte_v[6:0], sub_ff);
               end
            end
            default: begin
               sub_in  = byte_v;
               pbc_in  = 2'd0;
               fill_in = 7'd0;
               off_in  = 13'd0;
               col_in  = 7'd0;
               if (byte_v == SUBENC_RAW) begin
                  phase_in = PH_RAW;
               end else if (byte_v == SUBENC_SOLID) begin
                  phase_in = PH_SOLID;
               end else if (byte_v <= SUBENC_PACK_MAX || byte_v >= SUBENC_PRLE_MIN) begin
                  phase_in = PH_PALETTE;
               end else if (byte_v == SUBENC_PLAIN_RLE) begin
                  phase_in = PH_PLAIN_PIX;
               end else begin
                  phase_in = PH_SUBENC;
                  fin_in   = 1'b1;
                  run_valid = 1'b1;
                  run.rsp.run_start  = 12'd0;
                  run.rsp.error_code = ERR_SUBENC;
               end
            end
         endcase
      end

      ovf  = req_len > {5'd0, remain};
      ends = ({5'd0, off_ff} + req_len) == {5'd0, area};
      nx   = {1'b0, tx_ff} + 17'(TILE_SIZE);
      ny   = {1'b0, ty_ff} + 17'(TILE_SIZE);
      if (req_run) begin
         run_valid = 1'b1;
         if (ovf) begin
            run.rsp.error_code = ERR_OVERFLOW;
            fin_in    = 1'b1;
            byte_done = 1'b1;
         end else begin
            run.rsp.run_len     = req_len[12:0];
            run.rsp.pixel_value = req_val;
            run.from_palette    = req_pal;
            run.pal_index       = req_idx;
            if (!ends) begin
               off_in = off_ff + req_len[12:0];
            end else begin
               byte_done = 1'b1;
               run.rsp.tile_done = 1'b1;
               if (nx < {1'b0, cfg.rect_width}) begin
                  tx_in = nx[15:0];
               end else if (ny < {1'b0, cfg.rect_height}) begin
                  tx_in = 16'd0;
                  ty_in = ny[15:0];
               end else begin
                  run.rsp.rect_done = 1'b1;
                  fin_in = 1'b1;
               end
               off_in   = 13'd0;
               col_in   = 7'd0;
               phase_in = PH_SUBENC;
            end
         end
      end

      act_after = !fin_in && (tx_in < cfg.rect_width) && (ty_in < cfg.rect_height);
      if (byte_done && req_data.stream_end) begin
         if (act && act_after) begin
            if (!run_valid) begin
               run_valid = 1'b1;
               run.rsp.run_start = off_in[11:0];
            end
            run.rsp.error_code = ERR_TRUNCATED;
         end
         phase_in = PH_SUBENC;
         sub_in   = 8'd0;
         fill_in  = 7'd0;
         pix_in   = 32'd0;
         pbc_in   = 2'd0;
         tx_in    = 16'd0;
         ty_in    = 16'd0;
         off_in   = 13'd0;
         acc_in   = 17'd0;
         col_in   = 7'd0;
         fin_in   = 1'b0;
      end
      run.rsp.last_of_byte = byte_done;
      q_in = byte_done ? 3'd0 : q_ff + 3'd1;
      run_valid = run_valid && fire;
      req_stall = !(run_ready && byte_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SUBENC;
         sub_ff   <= 8'd0;
         fill_ff  <= 7'd0;
         pix_ff   <= 32'd0;
         pbc_ff   <= 2'd0;
         tx_ff    <= 16'd0;
         ty_ff    <= 16'd0;
         off_ff   <= 13'd0;
         acc_ff   <= 17'd0;
         col_ff   <= 7'd0;
         fin_ff   <= 1'b0;
         q_ff     <= 3'd0;
         idx_ff   <= 7'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         sub_ff   <= sub_in;
         fill_ff  <= fill_in;
         pix_ff   <= pix_in;
         pbc_ff   <= pbc_in;
         tx_ff    <= tx_in;
         ty_ff    <= ty_in;
         off_ff   <= off_in;
         acc_ff   <= acc_in;
         col_ff   <= col_in;
         fin_ff   <= fin_in;
         q_ff     <= q_in;
         idx_ff   <= idx_in;
      end
   end

   a_q_only_packed: assert property (@(posedge clock) disable iff (reset)
      (q_ff != 3'd0) |-> (phase_ff == PH_PACKED))
      else $error("Packed index counter is active outside packed phase.");

   a_no_run_when_finished: assert property (@(posedge clock) disable iff (reset)
      run_valid |-> !fin_ff)
      else $error("A transaction was produced after decoding stopped.");

   a_offset_in_tile: assert property (@(posedge clock) disable iff (reset)
      off_ff <= 13'(TILE_SIZE * TILE_SIZE))
      else $error("Tile pixel offset is beyond the tile area.");

endmodule
`default_nettype wire

// ===== hdl/zrle_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrle_out_stage
// Palette lookup stage and output register of the result channel.
// ----------------------------------------------------------------------------
module zrle_out_stage
   import zrle_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          run_valid,
   input  wire zrle_run_type  run,
   output logic               run_ready,
   input  wire logic [31:0]   pal_rd_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output zrle_rsp_type       rsp_data
);

   logic         s1_valid_ff;
   zrle_run_type s1_ff;
   logic         out_valid_ff;
   zrle_rsp_type out_ff, out_in;
   logic         move;

   always_comb begin
      move      = !out_valid_ff || !rsp_stall;
      run_ready = !s1_valid_ff || move;
      out_in    = s1_ff.rsp;
      if (s1_ff.from_palette) begin
         out_in.pixel_value = pal_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (move) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (run_ready) begin
            s1_valid_ff <= run_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move && s1_valid_ff) begin
         out_ff <= out_in;
      end
      if (run_ready && run_valid) begin
         s1_ff <= run;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("A pending transaction was dropped while the output was stalled.");

endmodule
`default_nettype wire

// ===== hdl/zrle_tile_stream_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// zrle_tile_stream_decoder
// ZRLE tile stream decoder: parses inflated bytes into pixel-run transactions.
// ----------------------------------------------------------------------------
// A transaction is registered in the palette lookup stage, then in the output register.
// One byte per cycle is taken while req_stall is low; a packed palette byte is held
// until each decoded pixel (up to 8) is issued, as each pixel is one palette read.
// Reset is synchronous; it clears control state and valid flags, sets 3-byte pixels
// and leaves palette memory uncleared; its read data is used only for palette runs.
module zrle_tile_stream_decoder
   import zrle_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire zrle_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output zrle_rsp_type      rsp_data,
   input  wire logic         csr_write_enable,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_write_data
);

   zrle_cfg_type      cfg_ff;
   logic              run_valid, run_ready;
   zrle_run_type      run;
   logic              pal_wr_en;
   logic [PAL_AW-1:0] pal_wr_addr;
   logic [31:0]       pal_wr_data;
   logic [31:0]       pal_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rect_width       <= 16'd0;
         cfg_ff.rect_height      <= 16'd0;
         cfg_ff.bytes_per_cpixel <= 3'd3;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RECT_WIDTH:  cfg_ff.rect_width       <= csr_write_data;
            CSR_RECT_HEIGHT: cfg_ff.rect_height      <= csr_write_data;
            CSR_CPIXEL:      cfg_ff.bytes_per_cpixel <= csr_write_data[2:0];
            default: begin
            end
         endcase
      end
   end

   zrle_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .run_ready   (run_ready),
      .run_valid   (run_valid),
      .run         (run),
      .pal_wr_en   (pal_wr_en),
      .pal_wr_addr (pal_wr_addr),
      .pal_wr_data (pal_wr_data)
   );

   zrle_palette_ram u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (pal_wr_data),
      .rd_en   (run_valid && run_ready),
      .rd_addr (run.pal_index),
      .rd_data (pal_rd_data)
   );

   zrle_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .run_valid   (run_valid),
      .run         (run),
      .run_ready   (run_ready),
      .pal_rd_data (pal_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
